// File: hw/rtl/pfrm_pkg.sv
// Shared types and constants of the per-flow smoothed rate meter.
// Used by pfrm_front, pfrm_back and the top level; depends on nothing.
package pfrm_pkg;

    localparam int DEF_FLOWS   = 16;
    localparam int FLOW_W      = 4;
    localparam int VAL_W       = 31;
    localparam int MODE_W      = 3;
    localparam int KIND_W      = 2;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 72;
    localparam int M_PAD_W     = M_DATA_W - (FLOW_W + VAL_W + 1 + VAL_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_ADD         = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET_LIMIT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR_LIMIT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TICK        = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY       = 3'd5;

    localparam logic [KIND_W-1:0] KIND_FLOW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GLOBAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SET_LIMIT,
        OP_CLEAR_LIMIT,
        OP_REMOVE,
        OP_TICK,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [FLOW_W-1:0] flow;
        logic              in_table;
        logic [VAL_W-1:0]  amount;
    } t_cmd;

endpackage

// File: hw/rtl/pfrm_front.sv
// Front end: accepts items, decodes the mode and queues commands for the back end.
// Depends on pfrm_pkg.
module pfrm_front #(
    parameter int FLOWS = pfrm_pkg::DEF_FLOWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [pfrm_pkg::MODE_W-1:0] i_mode,
    input  logic [pfrm_pkg::FLOW_W-1:0] i_flow,
    input  logic [pfrm_pkg::VAL_W-1:0]  i_amount,
    output logic                        o_cmd_valid,
    output pfrm_pkg::t_cmd              o_cmd,
    input  logic                        i_cmd_pop
);

    localparam int CNT_W = $clog2(FLOWS + 1);
    localparam int CMP_W = CNT_W + pfrm_pkg::FLOW_W;

    pfrm_pkg::t_cmd                    r_queue [pfrm_pkg::QUEUE_DEPTH];
    logic [pfrm_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [pfrm_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [pfrm_pkg::QPTR_W:0]         r_count;
    pfrm_pkg::t_cmd                    cmd;
    logic                              keep;
    logic                              in_table;
    logic                              push;
    logic                              pop;

    assign in_table = CMP_W'(i_flow) < CMP_W'(FLOWS);

    always_comb begin
        cmd.flow     = i_flow;
        cmd.amount   = i_amount;
        cmd.in_table = in_table;
        cmd.op       = pfrm_pkg::OP_ADD;
        keep         = 1'b0;
        case (i_mode)
            pfrm_pkg::MODE_ADD: begin
                cmd.op = pfrm_pkg::OP_ADD;
                keep   = in_table;
            end
            pfrm_pkg::MODE_SET_LIMIT: begin
                cmd.op = pfrm_pkg::OP_SET_LIMIT;
                keep   = in_table;
            end
            pfrm_pkg::MODE_CLEAR_LIMIT: begin
                cmd.op = pfrm_pkg::OP_CLEAR_LIMIT;
                keep   = in_table;
            end
            pfrm_pkg::MODE_REMOVE: begin
                cmd.op = pfrm_pkg::OP_REMOVE;
                keep   = in_table;
            end
            pfrm_pkg::MODE_TICK: begin
                cmd.op = pfrm_pkg::OP_TICK;
                keep   = 1'b1;
            end
            pfrm_pkg::MODE_QUERY: begin
                cmd.op = pfrm_pkg::OP_QUERY;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready     = r_count != (pfrm_pkg::QPTR_W + 1)'(pfrm_pkg::QUEUE_DEPTH);
    assign o_cmd_valid = r_count != '0;
    assign o_cmd       = r_queue[r_rd_ptr];
    assign push        = i_valid && o_ready && keep;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/pfrm_back.sv
// Back end: flow record memories, command sequencer, tick walk and result register.
// Depends on pfrm_pkg; fed by pfrm_front.
module pfrm_back #(
    parameter int FLOWS = pfrm_pkg::DEF_FLOWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  pfrm_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    input  logic [pfrm_pkg::VAL_W-1:0]  i_global_limit,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pfrm_pkg::KIND_W-1:0] o_kind,
    output logic [pfrm_pkg::FLOW_W-1:0] o_flow_index,
    output logic [pfrm_pkg::VAL_W-1:0]  o_speed,
    output logic                        o_limit_reached,
    output logic [pfrm_pkg::VAL_W-1:0]  o_available,
    output logic                        o_last
);

    localparam int IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int EXT_W = IDX_W + pfrm_pkg::FLOW_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOWS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_SUM,
        S_FINAL
    } t_state;

    function automatic logic [pfrm_pkg::VAL_W-1:0] sat_add(
        input logic [pfrm_pkg::VAL_W-1:0] a,
        input logic [pfrm_pkg::VAL_W-1:0] b
    );
        logic [pfrm_pkg::VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[pfrm_pkg::VAL_W] ? pfrm_pkg::VAL_MAX : s[pfrm_pkg::VAL_W-1:0];
    endfunction

    logic [pfrm_pkg::VAL_W-1:0] r_lim_mem   [FLOWS];
    logic [pfrm_pkg::VAL_W-1:0] r_bytes_mem [FLOWS];
    logic [pfrm_pkg::VAL_W-1:0] r_speed_mem [FLOWS];
    logic [pfrm_pkg::VAL_W-1:0] r_q_lim;
    logic [pfrm_pkg::VAL_W-1:0] r_q_bytes;
    logic [pfrm_pkg::VAL_W-1:0] r_q_speed;

    t_state                      r_state,   n_state;
    pfrm_pkg::t_cmd              r_cmd,     n_cmd;
    logic [IDX_W-1:0]            r_addr,    n_addr;
    logic [FLOWS-1:0]            r_present, n_present;
    logic [pfrm_pkg::VAL_W-1:0]  r_sum,     n_sum;
    logic [pfrm_pkg::VAL_W-1:0]  r_pend,    n_pend;
    logic                        r_pend_v,  n_pend_v;
    logic                        r_out_valid, n_out_valid;
    logic [pfrm_pkg::KIND_W-1:0] r_kind,    n_kind;
    logic [pfrm_pkg::FLOW_W-1:0] r_flow,    n_flow;
    logic [pfrm_pkg::VAL_W-1:0]  r_speed,   n_speed;
    logic                        r_hit,     n_hit;
    logic [pfrm_pkg::VAL_W-1:0]  r_avail,   n_avail;
    logic                        r_last,    n_last;

    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic                        we_lim, we_bytes, we_speed;
    logic [pfrm_pkg::VAL_W-1:0]  wd_lim, wd_bytes, wd_speed;
    logic [EXT_W-1:0]            head_ext;
    logic [IDX_W-1:0]            head_addr;
    logic [EXT_W-1:0]            idx_ext;
    logic                        present;
    logic [pfrm_pkg::VAL_W-1:0]  cur_lim, cur_bytes, cur_speed;
    logic [pfrm_pkg::VAL_W-1:0]  addend, new_speed, query_lim, query_avail;
    logic                        out_free;
    logic                        step;

    assign head_ext  = EXT_W'(i_cmd.flow);
    assign head_addr = head_ext[IDX_W-1:0];
    assign idx_ext   = EXT_W'(r_addr);
    assign present   = r_present[r_addr];
    assign cur_lim   = present ? r_q_lim   : '0;
    assign cur_bytes = present ? r_q_bytes : '0;
    assign cur_speed = present ? r_q_speed : '0;
    assign addend    = (cur_speed == '0 && cur_bytes != '0) ? cur_bytes : (cur_speed >> 1);
    assign new_speed = sat_add(cur_bytes, addend);
    assign query_lim = (r_cmd.in_table && present) ? r_q_lim : '0;
    assign out_free  = !r_out_valid || i_ready;

    always_comb begin
        if (query_lim == '0) begin
            query_avail = i_global_limit;
        end else if (i_global_limit != '0 && i_global_limit < query_lim) begin
            query_avail = i_global_limit;
        end else begin
            query_avail = query_lim;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_present   = r_present;
        n_sum       = sat_add(r_sum, r_pend_v ? r_pend : '0);
        n_pend      = r_pend;
        n_pend_v    = 1'b0;
        n_out_valid = (r_out_valid && i_ready) ? 1'b0 : r_out_valid;
        n_kind      = r_kind;
        n_flow      = r_flow;
        n_speed     = r_speed;
        n_hit       = r_hit;
        n_avail     = r_avail;
        n_last      = r_last;
        o_cmd_pop   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_addr + 1'b1;
        we_lim      = 1'b0;
        we_bytes    = 1'b0;
        we_speed    = 1'b0;
        wd_lim      = '0;
        wd_bytes    = '0;
        wd_speed    = '0;
        step        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    rd_en     = 1'b1;
                    if (i_cmd.op == pfrm_pkg::OP_TICK) begin
                        rd_addr = '0;
                        n_addr  = '0;
                        n_sum   = '0;
                        n_state = S_TICK;
                    end else begin
                        rd_addr = head_addr;
                        n_addr  = head_addr;
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_cmd.op)
                    pfrm_pkg::OP_ADD: begin
                        we_bytes = 1'b1;
                        wd_bytes = sat_add(cur_bytes, r_cmd.amount);
                        if (!present) begin
                            we_lim            = 1'b1;
                            we_speed          = 1'b1;
                            n_present[r_addr] = 1'b1;
                        end
                    end
                    pfrm_pkg::OP_SET_LIMIT: begin
                        we_lim = 1'b1;
                        wd_lim = r_cmd.amount;
                        if (!present) begin
                            we_bytes          = 1'b1;
                            we_speed          = 1'b1;
                            n_present[r_addr] = 1'b1;
                        end
                    end
                    pfrm_pkg::OP_CLEAR_LIMIT: begin
                        we_lim = present;
                    end
                    pfrm_pkg::OP_REMOVE: begin
                        n_present[r_addr] = 1'b0;
                    end
                    pfrm_pkg::OP_QUERY: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_kind      = pfrm_pkg::KIND_QUERY;
                            n_flow      = r_cmd.flow;
                            n_speed     = '0;
                            n_hit       = 1'b0;
                            n_avail     = query_avail;
                            n_last      = 1'b1;
                        end else begin
                            n_state = S_EXEC;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_TICK: begin
                if (!present) begin
                    step = 1'b1;
                end else if (out_free) begin
                    step        = 1'b1;
                    we_speed    = 1'b1;
                    wd_speed    = new_speed;
                    we_bytes    = 1'b1;
                    n_pend      = new_speed;
                    n_pend_v    = 1'b1;
                    n_out_valid = 1'b1;
                    n_kind      = pfrm_pkg::KIND_FLOW;
                    n_flow      = idx_ext[pfrm_pkg::FLOW_W-1:0];
                    n_speed     = new_speed;
                    n_hit       = (cur_lim != '0) && (new_speed >= cur_lim);
                    n_avail     = '0;
                    n_last      = 1'b0;
                end
                if (step) begin
                    if (r_addr == LAST_IDX) begin
                        n_state = S_SUM;
                    end else begin
                        rd_en  = 1'b1;
                        n_addr = r_addr + 1'b1;
                    end
                end
            end
            S_SUM: begin
                n_state = S_FINAL;
            end
            S_FINAL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = pfrm_pkg::KIND_GLOBAL;
                    n_flow      = '0;
                    n_speed     = r_sum;
                    n_hit       = (i_global_limit != '0) && (r_sum >= i_global_limit);
                    n_avail     = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_lim) begin
            r_lim_mem[r_addr] <= wd_lim;
        end
        if (we_bytes) begin
            r_bytes_mem[r_addr] <= wd_bytes;
        end
        if (we_speed) begin
            r_speed_mem[r_addr] <= wd_speed;
        end
        if (rd_en) begin
            r_q_lim   <= r_lim_mem[rd_addr];
            r_q_bytes <= r_bytes_mem[rd_addr];
            r_q_speed <= r_speed_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
        r_cmd   <= n_cmd;
        r_addr  <= n_addr;
        r_sum   <= n_sum;
        r_pend  <= n_pend;
        r_kind  <= n_kind;
        r_flow  <= n_flow;
        r_speed <= n_speed;
        r_hit   <= n_hit;
        r_avail <= n_avail;
        r_last  <= n_last;
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_kind;
    assign o_flow_index    = r_flow;
    assign o_speed         = r_speed;
    assign o_limit_reached = r_hit;
    assign o_available     = r_avail;
    assign o_last          = r_last;

endmodule

// File: hw/rtl/per_flow_ewma_rate_meter.sv
// Per-flow smoothed rate meter, top level: stream ports and the global limit register.
// Depends on pfrm_pkg, pfrm_front and pfrm_back.
//
// Input beats carry a mode in tuser and a flow index and amount in tdata: add
// bytes, set or clear a flow limit, remove a record, tick, or query. A front
// end decodes each beat into a four-entry command queue; tready falls only
// when that queue is full. Beats that change nothing are dropped there.
// The back end runs one command at a time out of record memories with a
// registered read, taking no new command until the last one is done; a query
// gives its answer beat from the execute state once the output register is free.
// A tick walks every table entry (FLOWS); it emits one beat per present flow in
// index order and, after a sum state, a closing global beat with tlast.
// Results wait in an output register; while the receiver holds tready low the
// back end stalls on its next result and the queue keeps filling.
// The global limit is written through the configuration port; write it only
// while idle, as the block itself does not enforce this.
// Reset empties the queue, marks every record absent and clears the limit;
// no clearing pass is needed.
module per_flow_ewma_rate_meter #(
    parameter int FLOWS = pfrm_pkg::DEF_FLOWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [pfrm_pkg::S_DATA_W-1:0] i_s_axis_tdata,   // flow, amount, zero pad
    input  logic [pfrm_pkg::MODE_W-1:0]   i_s_axis_tuser,   // mode
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [pfrm_pkg::M_DATA_W-1:0] o_m_axis_tdata,   // flow_index, speed,
                                                            // limit_reached, available, pad
    output logic [pfrm_pkg::KIND_W-1:0]   o_m_axis_tuser,   // kind
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_wr_en,
    input  logic [pfrm_pkg::VAL_W-1:0]    i_cfg_wr_data
);

    logic [pfrm_pkg::VAL_W-1:0]  r_global_limit;
    logic                        cmd_valid;
    pfrm_pkg::t_cmd              cmd;
    logic                        cmd_pop;
    logic [pfrm_pkg::FLOW_W-1:0] out_flow;
    logic [pfrm_pkg::VAL_W-1:0]  out_speed;
    logic                        out_hit;
    logic [pfrm_pkg::VAL_W-1:0]  out_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_limit <= '0;
        end else if (i_cfg_wr_en) begin
            r_global_limit <= i_cfg_wr_data;
        end
    end

    pfrm_front #(
        .FLOWS (FLOWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_flow      (i_s_axis_tdata[pfrm_pkg::FLOW_W-1:0]),
        .i_amount    (i_s_axis_tdata[pfrm_pkg::FLOW_W +: pfrm_pkg::VAL_W]),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    pfrm_back #(
        .FLOWS (FLOWS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .i_global_limit  (r_global_limit),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_kind          (o_m_axis_tuser),
        .o_flow_index    (out_flow),
        .o_speed         (out_speed),
        .o_limit_reached (out_hit),
        .o_available     (out_avail),
        .o_last          (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{pfrm_pkg::M_PAD_W{1'b0}}, out_avail, out_hit, out_speed, out_flow};

endmodule

// File: tb/sv/per_flow_ewma_rate_meter_test.sv
// Self-checking bench for the per-flow smoothed rate meter: a queue-fed stream driver,
// a checking monitor and an in-bench model of the flow table. Depends on pfrm_pkg.
`timescale 1ns / 1ps

module per_flow_ewma_rate_meter_test;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int CHOKE_CYCLES  = 400;
    localparam int FLOW_COUNT    = 16;
    localparam int CHUNK_ITEMS   = 56;
    localparam int REPORT_CAP    = 40;

    localparam logic [pfrm_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [pfrm_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef logic [pfrm_pkg::VAL_W-1:0]  t_val;
    typedef logic [pfrm_pkg::FLOW_W-1:0] t_flow;

    typedef struct {
        logic [pfrm_pkg::MODE_W-1:0] mode;
        t_flow                       flow;
        t_val                        amount;
    } t_meter_item;

    typedef struct {
        logic [pfrm_pkg::KIND_W-1:0] kind;
        t_flow                       flow;
        t_val                        speed;
        logic                        capped;
        t_val                        avail;
        logic                        last;
    } t_meter_beat;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [pfrm_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic [pfrm_pkg::MODE_W-1:0]   s_tuser = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [pfrm_pkg::M_DATA_W-1:0] m_tdata;
    logic [pfrm_pkg::KIND_W-1:0]   m_tuser;
    logic                          m_tlast;
    logic                          cfg_wr_en = 1'b0;
    t_val                          cfg_wr_data = '0;

    // flow table as the block should hold it
    logic                flow_present [FLOW_COUNT];
    t_val                flow_cap     [FLOW_COUNT];
    t_val                flow_bytes   [FLOW_COUNT];
    t_val                flow_rate    [FLOW_COUNT];
    t_val                global_cap = '0;

    t_meter_item pending_items [$];
    t_meter_beat awaited_beats [$];
    t_meter_item in_flight;

    int  beats_offered  = 0;
    int  beats_accepted = 0;
    int  results_seen   = 0;
    int  ticks_sent     = 0;
    int  queries_sent   = 0;
    int  cap_writes     = 0;
    int  error_count    = 0;
    int  cycle_count    = 0;
    int  tx_gap         = 0;
    int  tx_steady      = 0;
    int  rx_hold        = 0;
    int  rx_steady      = 0;
    int  choke_cycles   = 0;
    logic choke    = 1'b0;
    logic choke_go = 1'b0;

    per_flow_ewma_rate_meter dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        for (int i = 0; i < FLOW_COUNT; i++) begin
            flow_present[i] = 1'b0;
            flow_cap[i]     = '0;
            flow_bytes[i]   = '0;
            flow_rate[i]    = '0;
        end
    end

    function automatic t_val sat_sum(input t_val a, input t_val b);
        logic [pfrm_pkg::VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[pfrm_pkg::VAL_W] ? pfrm_pkg::VAL_MAX : s[pfrm_pkg::VAL_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what);
        if (error_count < REPORT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    task automatic predict_meter_beats(input t_meter_item it);
        t_val             total;
        t_val             rate;
        t_val             lim;
        t_meter_beat      b;
        total = '0;
        case (it.mode)
            pfrm_pkg::MODE_ADD: begin
                if (!flow_present[it.flow]) begin
                    flow_present[it.flow] = 1'b1;
                    flow_cap[it.flow]     = '0;
                    flow_bytes[it.flow]   = '0;
                    flow_rate[it.flow]    = '0;
                end
                flow_bytes[it.flow] = sat_sum(flow_bytes[it.flow], it.amount);
            end
            pfrm_pkg::MODE_SET_LIMIT: begin
                if (!flow_present[it.flow]) begin
                    flow_present[it.flow] = 1'b1;
                    flow_bytes[it.flow]   = '0;
                    flow_rate[it.flow]    = '0;
                end
                flow_cap[it.flow] = it.amount;
            end
            pfrm_pkg::MODE_CLEAR_LIMIT: begin
                if (flow_present[it.flow])
                    flow_cap[it.flow] = '0;
            end
            pfrm_pkg::MODE_REMOVE: begin
                flow_present[it.flow] = 1'b0;
                flow_cap[it.flow]     = '0;
                flow_bytes[it.flow]   = '0;
                flow_rate[it.flow]    = '0;
            end
            pfrm_pkg::MODE_TICK: begin
                for (int i = 0; i < FLOW_COUNT; i++) begin
                    if (flow_present[i]) begin
                        // first data counts the bytes twice, else bytes plus half the old speed
                        if (flow_rate[i] == '0 && flow_bytes[i] != '0)
                            rate = sat_sum(flow_bytes[i], flow_bytes[i]);
                        else
                            rate = sat_sum(flow_bytes[i], flow_rate[i] >> 1);
                        flow_rate[i]  = rate;
                        flow_bytes[i] = '0;
                        total         = sat_sum(total, rate);
                        b.kind   = pfrm_pkg::KIND_FLOW;
                        b.flow   = i[pfrm_pkg::FLOW_W-1:0];
                        b.speed  = rate;
                        b.capped = (flow_cap[i] != '0 && rate >= flow_cap[i]);
                        b.avail  = '0;
                        b.last   = 1'b0;
                        awaited_beats.push_back(b);
                    end
                end
                b.kind   = pfrm_pkg::KIND_GLOBAL;
                b.flow   = '0;
                b.speed  = total;
                b.capped = (global_cap != '0 && total >= global_cap);
                b.avail  = '0;
                b.last   = 1'b1;
                awaited_beats.push_back(b);
            end
            pfrm_pkg::MODE_QUERY: begin
                lim = flow_present[it.flow] ? flow_cap[it.flow] : '0;
                b.kind   = pfrm_pkg::KIND_QUERY;
                b.flow   = it.flow;
                b.speed  = '0;
                b.capped = 1'b0;
                b.avail  = (lim != '0) ? lim : global_cap;
                if (global_cap != '0 && lim != '0 && global_cap < b.avail)
                    b.avail = global_cap;
                b.last   = 1'b1;
                awaited_beats.push_back(b);
            end
            default: begin
            end
        endcase
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        if (roll < 95)
            return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int draw_sender_gap();
        if (tx_steady > 0) begin
            tx_steady--;
            return 0;
        end
        if ($urandom_range(0, 99) == 0) begin
            tx_steady = $urandom_range(30, 120);
            return 0;
        end
        if ($urandom_range(0, 99) < 55)
            return 0;
        return pick_gap();
    endfunction

    // stream driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_meter_beats(in_flight);
                beats_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_flight = pending_items.pop_front();
                    s_tuser <= in_flight.mode;
                    s_tdata <= {{(pfrm_pkg::S_DATA_W - pfrm_pkg::FLOW_W - pfrm_pkg::VAL_W){1'b0}},
                                in_flight.amount, in_flight.flow};
                    s_valid <= 1'b1;
                    tx_gap = draw_sender_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge clk) begin
        t_meter_beat got;
        t_meter_beat want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                got.kind   = m_tuser;
                got.flow   = m_tdata[pfrm_pkg::FLOW_W-1:0];
                got.speed  = m_tdata[pfrm_pkg::FLOW_W +: pfrm_pkg::VAL_W];
                got.capped = m_tdata[pfrm_pkg::FLOW_W + pfrm_pkg::VAL_W];
                got.avail  = m_tdata[pfrm_pkg::FLOW_W + pfrm_pkg::VAL_W + 1 +: pfrm_pkg::VAL_W];
                got.last   = m_tlast;
                if (awaited_beats.size() == 0) begin
                    flag_mismatch($sformatf("result beat kind %0d flow %0d with none awaited",
                                            got.kind, got.flow));
                end else begin
                    want = awaited_beats.pop_front();
                    if (got.kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
                    if (got.flow !== want.flow)
                        flag_mismatch($sformatf("flow_index %0d, want %0d",
                                                got.flow, want.flow));
                    if (got.speed !== want.speed)
                        flag_mismatch($sformatf("speed %0d, want %0d (flow %0d)",
                                                got.speed, want.speed, want.flow));
                    if (got.capped !== want.capped)
                        flag_mismatch($sformatf("limit_reached %0b, want %0b (flow %0d)",
                                                got.capped, want.capped, want.flow));
                    if (got.avail !== want.avail)
                        flag_mismatch($sformatf("available %0d, want %0d (flow %0d)",
                                                got.avail, want.avail, want.flow));
                    if (got.last !== want.last)
                        flag_mismatch($sformatf("tlast %0b, want %0b", got.last, want.last));
                end
            end
            if (rx_hold > 0)
                rx_hold--;
            else if (rx_steady > 0)
                rx_steady--;
            else if ($urandom_range(0, 199) == 0)
                rx_steady = $urandom_range(50, 200);
            else if ($urandom_range(0, 3) == 0)
                rx_hold = pick_gap();
            m_ready <= !choke && rx_hold == 0;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin : receiver_choke
        wait (choke_go);
        @(posedge clk);
        choke <= 1'b1;
        for (choke_cycles = 0; choke_cycles < CHOKE_CYCLES; choke_cycles++)
            @(posedge clk);
        choke <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_beats.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic offer(input logic [pfrm_pkg::MODE_W-1:0] mode, input t_flow flow,
                         input t_val amount);
        t_meter_item it;
        it.mode   = mode;
        it.flow   = flow;
        it.amount = amount;
        pending_items.push_back(it);
        beats_offered++;
        if (mode == pfrm_pkg::MODE_TICK)
            ticks_sent++;
        if (mode == pfrm_pkg::MODE_QUERY)
            queries_sent++;
    endtask

    function automatic t_val draw_bytes();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 60)
            return t_val'($urandom_range(1, 3000));
        if (roll < 80)
            return t_val'($urandom_range(0, 1 << 20));
        if (roll < 90)
            return t_val'($urandom_range(0, pfrm_pkg::VAL_MAX));
        return t_val'(pfrm_pkg::VAL_MAX - $urandom_range(0, 15));
    endfunction

    function automatic t_val draw_cap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 60)
            return t_val'($urandom_range(1, 6000));
        if (roll < 80)
            return t_val'($urandom_range(0, pfrm_pkg::VAL_MAX));
        if (roll < 90)
            return pfrm_pkg::VAL_MAX;
        return t_val'(1);
    endfunction

    function automatic t_val draw_any();
        return t_val'($urandom_range(0, pfrm_pkg::VAL_MAX));
    endfunction

    task automatic offer_random(input int count);
        int placed;
        int roll;
        t_flow flow;
        placed = 0;
        while (placed < count) begin
            roll = $urandom_range(0, 99);
            flow = t_flow'($urandom_range(0, FLOW_COUNT - 1));
            placed++;
            if (roll < 36) begin
                offer(pfrm_pkg::MODE_ADD, flow, draw_bytes());
            end else if (roll < 48) begin
                offer(pfrm_pkg::MODE_SET_LIMIT, flow, draw_cap());
            end else if (roll < 55) begin
                offer(pfrm_pkg::MODE_CLEAR_LIMIT, flow, draw_any());
            end else if (roll < 61) begin
                offer(pfrm_pkg::MODE_REMOVE, flow, draw_any());
            end else if (roll < 76) begin
                offer(pfrm_pkg::MODE_TICK, flow, draw_any());
            end else if (roll < 95) begin
                offer(pfrm_pkg::MODE_QUERY, flow, draw_any());
            end else begin
                // ignored modes do not count toward the item total
                placed--;
                offer(roll[0] ? MODE_SPARE_HI : MODE_SPARE_LO, flow, draw_any());
            end
        end
    endtask

    task automatic settle();
        while (beats_accepted != beats_offered || awaited_beats.size() != 0)
            @(posedge clk);
        // let commands that give no result drain from the block
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_global_cap(input t_val value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        global_cap = value;
        cap_writes++;
    endtask

    initial begin : stimulus
        t_val cap_plan [0:5];
        cap_plan[0] = pfrm_pkg::VAL_MAX;
        cap_plan[1] = t_val'(1);
        cap_plan[2] = t_val'($urandom_range(1000, 20000));
        cap_plan[3] = t_val'($urandom_range(1, pfrm_pkg::VAL_MAX));
        cap_plan[4] = t_val'($urandom_range(2000, 8000));
        cap_plan[5] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        offer(pfrm_pkg::MODE_QUERY, 4'd0, '0);
        offer(pfrm_pkg::MODE_TICK, 4'd0, '0);
        offer(pfrm_pkg::MODE_ADD, 4'd0, pfrm_pkg::VAL_MAX);
        offer(pfrm_pkg::MODE_ADD, 4'd0, 31'd5);
        offer(pfrm_pkg::MODE_SET_LIMIT, 4'd15, pfrm_pkg::VAL_MAX);
        offer(pfrm_pkg::MODE_ADD, 4'd15, '0);
        offer(pfrm_pkg::MODE_CLEAR_LIMIT, 4'd7, pfrm_pkg::VAL_MAX);
        offer(pfrm_pkg::MODE_REMOVE, 4'd9, '0);
        offer(pfrm_pkg::MODE_SET_LIMIT, 4'd3, 31'd1);
        offer(pfrm_pkg::MODE_ADD, 4'd3, 31'd1);
        offer(pfrm_pkg::MODE_TICK, 4'd15, pfrm_pkg::VAL_MAX);
        offer(pfrm_pkg::MODE_ADD, 4'd3, '0);
        offer(pfrm_pkg::MODE_TICK, 4'd0, '0);
        offer(pfrm_pkg::MODE_QUERY, 4'd3, pfrm_pkg::VAL_MAX);
        offer(pfrm_pkg::MODE_QUERY, 4'd7, '0);
        offer(pfrm_pkg::MODE_CLEAR_LIMIT, 4'd3, '0);
        offer(pfrm_pkg::MODE_QUERY, 4'd3, '0);
        offer(pfrm_pkg::MODE_REMOVE, 4'd0, pfrm_pkg::VAL_MAX);
        offer(pfrm_pkg::MODE_QUERY, 4'd0, '0);
        offer(MODE_SPARE_LO, 4'd5, pfrm_pkg::VAL_MAX);
        offer(MODE_SPARE_HI, 4'd10, pfrm_pkg::VAL_MAX);
        offer(pfrm_pkg::MODE_QUERY, 4'd15, '0);
        offer(pfrm_pkg::MODE_TICK, 4'd0, '0);
        settle();

        for (int p = 0; p < 6; p++) begin
            write_global_cap(cap_plan[p]);
            if (p == 1)
                choke_go = 1'b1;
            offer_random(CHUNK_ITEMS);
            settle();
        end

        if (awaited_beats.size() != 0)
            flag_mismatch($sformatf("%0d result beats never arrived", awaited_beats.size()));
        $display("covered %0d input beats (%0d ticks, %0d queries) and %0d result beats",
                 beats_accepted, ticks_sent, queries_sent, results_seen);
        $display("across %0d global limit settings incl. zero, one and full scale; %0d errors",
                 cap_writes + 1, error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
